FILE: rtl/sw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the display encoder for the stopwatch controller.
// Used by sw_core and stopwatch_controller; depends on nothing else.

package sw_pkg;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  localparam logic [0:0] REG_MS_PER_HUNDREDTH = 1'b0;
  localparam logic [0:0] REG_MS_PER_RING_STEP = 1'b1;

  localparam logic [3:0] MS_PER_HUNDREDTH_RST = 4'd10;
  localparam logic [7:0] MS_PER_RING_STEP_RST = 8'd100;
  localparam logic [7:0] RING_RST             = 8'h01;

  localparam logic [6:0] HUNDREDTHS_MAX = 7'd99;
  localparam logic [5:0] SECONDS_MAX    = 6'd59;
  localparam logic [5:0] MINUTES_MAX    = 6'd59;
  localparam logic [4:0] HOURS_MAX      = 5'd23;

  localparam logic [7:0] CHAR_RUN   = 8'h72;  // 'r'
  localparam logic [7:0] CHAR_CLEAR = 8'h63;  // 'c'

  typedef struct packed {
    logic       ms_tick;
    logic       run_stop_press;
    logic       clear_press;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    mode_t      mode;
    logic [6:0] hundredths;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [7:0] ring_leds;
    logic       run_led;
    logic       stop_led;
  } result_t;

  // (minutes mod 10) * 1000 + seconds * 10 + hundredths / 10.
  // Division by ten uses the reciprocal 205 / 2048, exact for values below 180.
  function automatic logic [13:0] display_encode(input logic [5:0] mins,
                                                 input logic [5:0] secs,
                                                 input logic [6:0] hund);
    logic [14:0] hund_prod;
    logic [14:0] min_prod;
    logic [3:0]  tenths;
    logic [3:0]  min_quot;
    logic [5:0]  min_tens;
    logic [3:0]  min_units;
    hund_prod = {8'd0, hund} * 15'd205;
    tenths    = hund_prod[14:11];
    min_prod  = {9'd0, mins} * 15'd205;
    min_quot  = min_prod[14:11];
    min_tens  = 6'({2'd0, min_quot} * 6'd10);
    min_units = 4'(mins - min_tens);
    return {10'd0, min_units} * 14'd1000 + {8'd0, secs} * 14'd10 + {10'd0, tenths};
  endfunction

endpackage

FILE: rtl/sw_core.sv
`timescale 1ns / 1ps
// Stopwatch state: prescaler, time cascade, mode machine and LED ring.
// Depends on sw_pkg. State advances once per accepted word.

module sw_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  sw_pkg::item_t   item,
  input  logic [3:0]      ms_per_hundredth,
  input  logic [7:0]      ms_per_ring_step,
  output sw_pkg::result_t res
);

  sw_pkg::mode_t mode, mode_next;
  logic [7:0] pending, pending_next;
  logic [3:0] prescale, prescale_next;
  logic [7:0] ring_timer, ring_timer_next;
  logic [6:0] hundredths, hundredths_next;
  logic [5:0] seconds, seconds_next;
  logic [5:0] minutes, minutes_next;
  logic [4:0] hours, hours_next;
  logic [7:0] ring, ring_next;
  logic       run_led, run_led_next;
  logic       stop_led, stop_led_next;

  logic [3:0] period;
  logic       advance;

  always_comb begin
    period = (ms_per_hundredth == 4'd0) ? 4'd1 : ms_per_hundredth;

    pending_next    = item.rx_valid ? item.rx_byte : pending;
    prescale_next   = prescale;
    ring_timer_next = ring_timer;
    advance         = 1'b0;
    if (item.ms_tick) begin
      if ({1'b0, prescale} + 5'd1 >= {1'b0, period}) begin
        prescale_next = 4'd0;
        advance       = (mode == sw_pkg::MODE_RUN);
      end else begin
        prescale_next = prescale + 4'd1;
      end
      if (ring_timer < ms_per_ring_step) begin
        ring_timer_next = ring_timer + 8'd1;
      end
    end

    hundredths_next = hundredths;
    seconds_next    = seconds;
    minutes_next    = minutes;
    hours_next      = hours;
    if (advance) begin
      if (hundredths < sw_pkg::HUNDREDTHS_MAX) begin
        hundredths_next = hundredths + 7'd1;
      end else begin
        hundredths_next = 7'd0;
        if (seconds < sw_pkg::SECONDS_MAX) begin
          seconds_next = seconds + 6'd1;
        end else begin
          seconds_next = 6'd0;
          if (minutes < sw_pkg::MINUTES_MAX) begin
            minutes_next = minutes + 6'd1;
          end else begin
            minutes_next = 6'd0;
            hours_next   = (hours < sw_pkg::HOURS_MAX) ? hours + 5'd1 : 5'd0;
          end
        end
      end
    end

    mode_next = mode;
    unique case (mode)
      sw_pkg::MODE_STOP: begin
        if (item.run_stop_press) begin
          mode_next = sw_pkg::MODE_RUN;
        end else if (item.clear_press) begin
          mode_next = sw_pkg::MODE_CLEAR;
        end else if (pending_next == sw_pkg::CHAR_RUN) begin
          pending_next = 8'd0;
          mode_next    = sw_pkg::MODE_RUN;
        end else if (pending_next == sw_pkg::CHAR_CLEAR) begin
          pending_next = 8'd0;
          mode_next    = sw_pkg::MODE_CLEAR;
        end
      end
      sw_pkg::MODE_RUN: begin
        // A pending clear byte is left waiting while the watch runs.
        if (item.run_stop_press) begin
          mode_next = sw_pkg::MODE_STOP;
        end else if (pending_next == sw_pkg::CHAR_RUN) begin
          pending_next = 8'd0;
          mode_next    = sw_pkg::MODE_STOP;
        end
      end
      sw_pkg::MODE_CLEAR: begin
        mode_next       = sw_pkg::MODE_STOP;
        hundredths_next = 7'd0;
        seconds_next    = 6'd0;
        minutes_next    = 6'd0;
        hours_next      = 5'd0;
      end
      default: begin
        mode_next = sw_pkg::MODE_STOP;
      end
    endcase

    ring_next     = ring;
    run_led_next  = run_led;
    stop_led_next = stop_led;
    unique case (mode_next)
      sw_pkg::MODE_STOP: begin
        run_led_next  = 1'b0;
        stop_led_next = 1'b1;
      end
      sw_pkg::MODE_RUN: begin
        run_led_next  = 1'b1;
        stop_led_next = 1'b0;
        if (ring_timer_next >= ms_per_ring_step) begin
          ring_timer_next = 8'd0;
          ring_next       = {ring[6:0], ring[7]};
        end
      end
      default: begin
        ring_next = sw_pkg::RING_RST;
      end
    endcase

    res.mode       = mode_next;
    res.hundredths = hundredths_next;
    res.seconds    = seconds_next;
    res.minutes    = minutes_next;
    res.hours      = hours_next;
    res.ring_leds  = ring_next;
    res.run_led    = run_led_next;
    res.stop_led   = stop_led_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= sw_pkg::MODE_STOP;
      pending    <= 8'd0;
      prescale   <= 4'd0;
      ring_timer <= 8'd0;
      hundredths <= 7'd0;
      seconds    <= 6'd0;
      minutes    <= 6'd0;
      hours      <= 5'd0;
      ring       <= sw_pkg::RING_RST;
      run_led    <= 1'b0;
      stop_led   <= 1'b0;
    end else if (step) begin
      mode       <= mode_next;
      pending    <= pending_next;
      prescale   <= prescale_next;
      ring_timer <= ring_timer_next;
      hundredths <= hundredths_next;
      seconds    <= seconds_next;
      minutes    <= minutes_next;
      hours      <= hours_next;
      ring       <= ring_next;
      run_led    <= run_led_next;
      stop_led   <= stop_led_next;
    end
  end

endmodule

FILE: rtl/stopwatch_controller.sv
`timescale 1ns / 1ps
// Stopwatch controller top level: configuration registers, state core and output stage.
// Depends on sw_pkg and sw_core.

// The block takes one input word per clock cycle while s_tready is high and returns
// one result word for each, in order. Each word carries a millisecond tick, the run/stop
// and clear button pulses and an optional received byte ('r' toggles run, 'c' clears).
// The state update is combinational logic ahead of the registers in sw_core, so the
// sustained rate is one word per cycle while m_tready is high. Each result is registered
// in an output register backed by a one-word skid stage, which lets the slave side keep
// accepting while a result waits; s_tready drops only when both hold a word. The two
// period registers should be written while no word is in flight.

module stopwatch_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // ms_tick, run_stop_press, clear_press, rx_valid, rx_byte[7:0], zero pad.
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // mode[1:0], hundredths[6:0], seconds[5:0], minutes[5:0], hours[4:0],
  // display_value[13:0], ring_leds[7:0], run_led, stop_led, zero pad.
  output logic [55:0] m_tdata
);

  logic [3:0] ms_per_hundredth;
  logic [7:0] ms_per_ring_step;

  sw_pkg::item_t   item;
  sw_pkg::result_t res;
  sw_pkg::result_t out_word;
  sw_pkg::result_t skid_word;
  logic            out_valid;
  logic            skid_valid;
  logic            accept;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_per_hundredth <= sw_pkg::MS_PER_HUNDREDTH_RST;
      ms_per_ring_step <= sw_pkg::MS_PER_RING_STEP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sw_pkg::REG_MS_PER_HUNDREDTH: ms_per_hundredth <= cfg_data[3:0];
        sw_pkg::REG_MS_PER_RING_STEP: ms_per_ring_step <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item.ms_tick        = s_tdata[0];
  assign item.run_stop_press = s_tdata[1];
  assign item.clear_press    = s_tdata[2];
  assign item.rx_valid       = s_tdata[3];
  assign item.rx_byte        = s_tdata[11:4];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  sw_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (accept),
    .item             (item),
    .ms_per_hundredth (ms_per_hundredth),
    .ms_per_ring_step (ms_per_ring_step),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= res;
      end
    end else if (accept) begin
      skid_word <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0,
                     out_word.stop_led,
                     out_word.run_led,
                     out_word.ring_leds,
                     sw_pkg::display_encode(out_word.minutes, out_word.seconds,
                                            out_word.hundredths),
                     out_word.hours,
                     out_word.minutes,
                     out_word.seconds,
                     out_word.hundredths,
                     out_word.mode};

endmodule
